// File: rtl/dual_channel_edge_rate_meter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge rate meter
// Shared concurrent assertion forms used by the block's controller.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_EDGE_RATE_METER_UNIT_ASSERT_SVH
`define DUAL_CHANNEL_EDGE_RATE_METER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DCERM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edge rate meter: same-cycle check failed");

// Next-cycle implication.
`define DCERM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edge rate meter: next-cycle check failed");

`endif

// File: rtl/dcerm_pkg.sv
// ----------------------------------------------------------------------------
// Edge rate meter package
// Constants, codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcerm_pkg;

   localparam int TIME_WIDTH_DEF      = 32;
   localparam int SPEED_FRAC_BITS_DEF = 8;

   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int KIND_W     = 2;
   localparam int SCALE_W    = 19;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_EDGES     = 1'd1;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [SCALE_W-1:0] SPEED_SCALE     = 19'd500000;
   localparam logic [15:0]        PERIOD_RESET    = 16'd100;
   localparam logic [7:0]         MIN_EDGES_RESET = 8'd2;

   typedef struct packed {
      logic latch;
      logic exec;
      logic mul_load;
      logic div_step;
      logic store;
      logic out_load;
      logic ch;
      logic recomp;
   } dp_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              period_ok;
      logic              div_last;
   } dp_status_type;

endpackage

// File: rtl/dcerm_if.sv
// ----------------------------------------------------------------------------
// Edge rate meter channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcerm_req_if;
   logic                               valid;
   logic                               ready;
   logic [dcerm_pkg::KIND_W-1:0]       kind;
   logic [dcerm_pkg::DATA_W-1:0]       time_us;
   logic [dcerm_pkg::DATA_W-1:0]       time_ms;
   logic                               left_level;
   logic                               right_level;

   modport source (output valid, kind, time_us, time_ms, left_level, right_level,
                   input ready);
   modport sink (input valid, kind, time_us, time_ms, left_level, right_level,
                 output ready);
endinterface

interface dcerm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dcerm_pkg::DATA_W-1:0]       left_speed;
   logic [dcerm_pkg::DATA_W-1:0]       right_speed;
   logic [dcerm_pkg::DATA_W-1:0]       left_total;
   logic [dcerm_pkg::DATA_W-1:0]       right_total;
   logic                               recomputed;

   modport source (output valid, left_speed, right_speed, left_total, right_total,
                   recomputed, input ready);
   modport sink (input valid, left_speed, right_speed, left_total, right_total,
                 recomputed, output ready);
endinterface

// File: rtl/dcerm_datapath.sv
// ----------------------------------------------------------------------------
// Edge rate meter datapath
// Channel state, configuration, shared multiplier and restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dcerm_datapath #(
   parameter int TIME_WIDTH      = dcerm_pkg::TIME_WIDTH_DEF,
   parameter int SPEED_FRAC_BITS = dcerm_pkg::SPEED_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dcerm_pkg::dp_cmd_type               cmd,
   output dcerm_pkg::dp_status_type            status,
   input  logic                                csr_we,
   input  logic [dcerm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dcerm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [dcerm_pkg::KIND_W-1:0]        in_kind,
   input  logic [dcerm_pkg::DATA_W-1:0]        in_time_us,
   input  logic [dcerm_pkg::DATA_W-1:0]        in_time_ms,
   input  logic [1:0]                          in_level,
   output logic [dcerm_pkg::DATA_W-1:0]        out_left_speed,
   output logic [dcerm_pkg::DATA_W-1:0]        out_right_speed,
   output logic [dcerm_pkg::DATA_W-1:0]        out_left_total,
   output logic [dcerm_pkg::DATA_W-1:0]        out_right_total,
   output logic                                out_recomputed
);

   localparam int DW    = dcerm_pkg::DATA_W;
   localparam int TW    = TIME_WIDTH;
   localparam int NUM_W = DW + dcerm_pkg::SCALE_W;
   localparam int NW    = NUM_W + SPEED_FRAC_BITS;
   localparam int CNT_W = $clog2(NW);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

   logic [dcerm_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [TW-1:0]                now_ff, now_in;
   logic [DW-1:0]                tms_ff, tms_in;
   logic [1:0]                   lv_ff, lv_in;

   logic [15:0]                  period_ff, period_in;
   logic [7:0]                   min_edges_ff, min_edges_in;

   logic                         prev_ff [2];
   logic                         prev_in [2];
   logic [TW-1:0]                last_edge_ff [2];
   logic [TW-1:0]                last_edge_in [2];
   logic [DW-1:0]                win_edges_ff [2];
   logic [DW-1:0]                win_edges_in [2];
   logic [TW-1:0]                win_time_ff [2];
   logic [TW-1:0]                win_time_in [2];
   logic [DW-1:0]                total_ff [2];
   logic [DW-1:0]                total_in [2];
   logic [DW-1:0]                speed_ff [2];
   logic [DW-1:0]                speed_in [2];
   logic [DW-1:0]                snap_cnt_ff [2];
   logic [DW-1:0]                snap_cnt_in [2];
   logic [TW-1:0]                snap_time_ff [2];
   logic [TW-1:0]                snap_time_in [2];
   logic [DW-1:0]                last_upd_ff, last_upd_in;

   logic [NW-1:0]                n_ff, n_in;
   logic [TW-1:0]                t_ff, t_in;
   logic [TW-1:0]                rem_ff, rem_in;
   logic [DW-1:0]                q_ff, q_in;
   logic                         ovf_ff, ovf_in;
   logic                         zero_ff, zero_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;

   logic [DW-1:0]                o_lspd_ff, o_lspd_in;
   logic [DW-1:0]                o_rspd_ff, o_rspd_in;
   logic [DW-1:0]                o_ltot_ff, o_ltot_in;
   logic [DW-1:0]                o_rtot_ff, o_rtot_in;
   logic                         o_rec_ff, o_rec_in;

   logic [NUM_W-1:0]             prod;
   logic [TW:0]                  r2;
   logic [TW:0]                  diff;
   logic                         ge;
   logic [DW-1:0]                ms_delta;

   assign ms_delta         = tms_ff - last_upd_ff;
   assign status.kind      = kind_ff;
   assign status.period_ok = (ms_delta >= {16'd0, period_ff});
   assign status.div_last  = (cnt_ff == CNT_LAST);

   assign prod = NUM_W'(snap_cnt_ff[cmd.ch]) * NUM_W'(dcerm_pkg::SPEED_SCALE);
   assign r2   = {rem_ff, n_ff[NW-1]};
   assign diff = r2 - {1'b0, t_ff};
   assign ge   = (r2 >= {1'b0, t_ff});

   always_comb begin
      kind_in      = kind_ff;
      now_in       = now_ff;
      tms_in       = tms_ff;
      lv_in        = lv_ff;
      period_in    = period_ff;
      min_edges_in = min_edges_ff;
      last_upd_in  = last_upd_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      zero_in      = zero_ff;
      cnt_in       = cnt_ff;
      o_lspd_in    = o_lspd_ff;
      o_rspd_in    = o_rspd_ff;
      o_ltot_in    = o_ltot_ff;
      o_rtot_in    = o_rtot_ff;
      o_rec_in     = o_rec_ff;
      for (int i = 0; i < 2; i++) begin
         prev_in[i]      = prev_ff[i];
         last_edge_in[i] = last_edge_ff[i];
         win_edges_in[i] = win_edges_ff[i];
         win_time_in[i]  = win_time_ff[i];
         total_in[i]     = total_ff[i];
         speed_in[i]     = speed_ff[i];
         snap_cnt_in[i]  = snap_cnt_ff[i];
         snap_time_in[i] = snap_time_ff[i];
      end

      if (csr_we) begin
         case (csr_index)
            dcerm_pkg::REG_SAMPLE_PERIOD: period_in    = csr_wdata;
            dcerm_pkg::REG_MIN_EDGES:     min_edges_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      if (cmd.latch) begin
         kind_in = in_kind;
         now_in  = TW'(in_time_us);
         tms_in  = in_time_ms;
         lv_in   = in_level;
      end

      if (cmd.exec) begin
         case (kind_ff)
            dcerm_pkg::KIND_SAMPLE: begin
               for (int i = 0; i < 2; i++) begin
                  if (lv_ff[i] != prev_ff[i]) begin
                     win_time_in[i]  = win_time_ff[i] + (now_ff - last_edge_ff[i]);
                     win_edges_in[i] = win_edges_ff[i] + DW'(1);
                     total_in[i]     = total_ff[i] + DW'(1);
                     prev_in[i]      = lv_ff[i];
                     last_edge_in[i] = now_ff;
                  end
               end
            end
            dcerm_pkg::KIND_UPDATE: begin
               if (status.period_ok) begin
                  for (int i = 0; i < 2; i++) begin
                     snap_cnt_in[i]  = win_edges_ff[i];
                     snap_time_in[i] = win_time_ff[i];
                     win_edges_in[i] = '0;
                     win_time_in[i]  = '0;
                     last_edge_in[i] = now_ff;
                  end
                  last_upd_in = tms_ff;
               end
            end
            dcerm_pkg::KIND_CLEAR: begin
               for (int i = 0; i < 2; i++) begin
                  win_edges_in[i] = '0;
                  win_time_in[i]  = '0;
                  total_in[i]     = '0;
                  prev_in[i]      = lv_ff[i];
                  last_edge_in[i] = now_ff;
               end
            end
            default: ;
         endcase
      end

      if (cmd.mul_load) begin
         n_in    = NW'(prod) << SPEED_FRAC_BITS;
         t_in    = snap_time_ff[cmd.ch];
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
         zero_in = (snap_cnt_ff[cmd.ch] < {24'd0, min_edges_ff}) ||
                   (snap_time_ff[cmd.ch] == '0);
      end

      if (cmd.div_step) begin
         rem_in = ge ? diff[TW-1:0] : r2[TW-1:0];
         n_in   = n_ff << 1;
         q_in   = {q_ff[DW-2:0], ge};
         ovf_in = ovf_ff | q_ff[DW-1];
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (cmd.store) begin
         speed_in[cmd.ch] = zero_ff ? '0 : (ovf_ff ? '1 : q_ff);
      end

      if (cmd.out_load) begin
         o_lspd_in = speed_ff[0];
         o_rspd_in = speed_ff[1];
         o_ltot_in = total_ff[0];
         o_rtot_in = total_ff[1];
         o_rec_in  = cmd.recomp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= dcerm_pkg::PERIOD_RESET;
         min_edges_ff <= dcerm_pkg::MIN_EDGES_RESET;
         last_upd_ff  <= '0;
         for (int i = 0; i < 2; i++) begin
            prev_ff[i]      <= 1'b1;
            last_edge_ff[i] <= '0;
            win_edges_ff[i] <= '0;
            win_time_ff[i]  <= '0;
            total_ff[i]     <= '0;
            speed_ff[i]     <= '0;
         end
      end else begin
         period_ff    <= period_in;
         min_edges_ff <= min_edges_in;
         last_upd_ff  <= last_upd_in;
         for (int i = 0; i < 2; i++) begin
            prev_ff[i]      <= prev_in[i];
            last_edge_ff[i] <= last_edge_in[i];
            win_edges_ff[i] <= win_edges_in[i];
            win_time_ff[i]  <= win_time_in[i];
            total_ff[i]     <= total_in[i];
            speed_ff[i]     <= speed_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      now_ff    <= now_in;
      tms_ff    <= tms_in;
      lv_ff     <= lv_in;
      n_ff      <= n_in;
      t_ff      <= t_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      ovf_ff    <= ovf_in;
      zero_ff   <= zero_in;
      cnt_ff    <= cnt_in;
      o_lspd_ff <= o_lspd_in;
      o_rspd_ff <= o_rspd_in;
      o_ltot_ff <= o_ltot_in;
      o_rtot_ff <= o_rtot_in;
      o_rec_ff  <= o_rec_in;
      for (int i = 0; i < 2; i++) begin
         snap_cnt_ff[i]  <= snap_cnt_in[i];
         snap_time_ff[i] <= snap_time_in[i];
      end
   end

   assign out_left_speed  = o_lspd_ff;
   assign out_right_speed = o_rspd_ff;
   assign out_left_total  = o_ltot_ff;
   assign out_right_total = o_rtot_ff;
   assign out_recomputed  = o_rec_ff;

endmodule

// File: rtl/dcerm_ctrl.sv
// ----------------------------------------------------------------------------
// Edge rate meter controller
// Sequences item execution, speed computation and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_channel_edge_rate_meter_unit_assert.svh"

module dcerm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dcerm_pkg::dp_cmd_type      cmd,
   input  dcerm_pkg::dp_status_type   status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_STORE = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       ch_ff, ch_in;
   logic       rec_ff, rec_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      rec_in   = rec_ff;
      valid_in = valid_ff;
      cmd      = '0;
      cmd.ch   = ch_ff;
      cmd.recomp = rec_ff;

      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.kind == dcerm_pkg::KIND_UPDATE && status.period_ok) begin
               ch_in    = 1'b0;
               rec_in   = 1'b1;
               state_in = ST_MUL;
            end else begin
               rec_in   = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= 1'b0;
         rec_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
         rec_ff   <= rec_in;
         valid_ff <= valid_in;
      end
   end

   `DCERM_ASSERT_NXT(a_accept_execs, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   `DCERM_ASSERT_NXT(a_out_loads, clock, reset, state_ff == ST_OUT && out_free, valid_ff)
   `DCERM_ASSERT_NXT(a_div_ends, clock, reset, state_ff == ST_DIV && status.div_last,
                     state_ff == ST_STORE)
   `DCERM_ASSERT_NXT(a_both_channels, clock, reset, state_ff == ST_STORE && ch_ff,
                     state_ff == ST_OUT && rec_ff)

endmodule

// File: rtl/dual_channel_edge_rate_meter_unit.sv
// ----------------------------------------------------------------------------
// Dual channel edge rate meter
// Counts sensor edges on two channels and computes average-period speeds.
// ----------------------------------------------------------------------------
// Items enter on req_chan: kind selects a pin sample, an update request or a
// clear of the counters. Every item produces one result item on rsp_chan
// with both speeds, both edge totals and a flag set when speeds were redone.
// The user must write registers through csr_we/csr_index/csr_wdata only while
// idle; the block itself does not enforce this. A sample, clear, unused or
// early update item passes through the EXEC and OUT states before its result
// is valid. An update that recomputes runs a shared multiplier and a
// one-bit-per-cycle restoring divider over both channels.
// The block holds one item at a time; the next item is taken once the
// previous result has moved into the output register.
// Reset is synchronous and returns counts, speeds and registers to their
// defaults. If the receiver stalls, the result stays in the output
// register and a finished second item waits until that register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dual_channel_edge_rate_meter_unit #(
   parameter int TIME_WIDTH      = dcerm_pkg::TIME_WIDTH_DEF,
   parameter int SPEED_FRAC_BITS = dcerm_pkg::SPEED_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   dcerm_req_if.sink                         req_chan,
   dcerm_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [dcerm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dcerm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   dcerm_pkg::dp_cmd_type    cmd;
   dcerm_pkg::dp_status_type status;

   dcerm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   dcerm_datapath #(
      .TIME_WIDTH      (TIME_WIDTH),
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_kind         (req_chan.kind),
      .in_time_us      (req_chan.time_us),
      .in_time_ms      (req_chan.time_ms),
      .in_level        ({req_chan.right_level, req_chan.left_level}),
      .out_left_speed  (rsp_chan.left_speed),
      .out_right_speed (rsp_chan.right_speed),
      .out_left_total  (rsp_chan.left_total),
      .out_right_total (rsp_chan.right_total),
      .out_recomputed  (rsp_chan.recomputed)
   );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Edge rate meter testbench
// Drives sample, update, clear and unused items through the request channel
// under several register settings, predicts result items in a local model of
// both wheel channels or takes them from directed rows, and checks every result
// field in order.
`timescale 1ns / 1ps

module tb;

   localparam logic [dcerm_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 2 * (51 + dcerm_pkg::SPEED_FRAC_BITS_DEF + 2) + 10;

   typedef struct packed {
      logic [dcerm_pkg::KIND_W-1:0] kind;
      logic [31:0]                  time_us;
      logic [31:0]                  time_ms;
      logic                         left_level;
      logic                         right_level;
   } meter_item_type;

   typedef struct packed {
      logic [31:0] left_speed;
      logic [31:0] right_speed;
      logic [31:0] left_total;
      logic [31:0] right_total;
      logic        recomputed;
   } reading_type;

   typedef struct packed {
      meter_item_type item;
      logic           typed;
      reading_type    reading;
   } directed_row_type;

   localparam reading_type NO_READING = '0;

   localparam directed_row_type DIRECTED_ROWS [0:22] = '{
      '{'{KIND_UNUSED, 32'h0, 32'h0, 1'b1, 1'b1}, 1'b1, '{32'd0, 32'd0, 32'd0, 32'd0, 1'b0}},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h10, 32'h0, 1'b0, 1'b0}, 1'b1,
        '{32'd0, 32'd0, 32'd1, 32'd1, 1'b0}},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h10, 32'h0, 1'b0, 1'b0}, 1'b1,
        '{32'd0, 32'd0, 32'd1, 32'd1, 1'b0}},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h20, 32'h0, 1'b1, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd2, 32'd2, 1'b0}},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h20, 32'd99, 1'b1, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd2, 32'd2, 1'b0}},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h40, 32'd100, 1'b1, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'hFFFF_FFF0, 32'h0, 1'b0, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h10, 32'h0, 1'b1, 1'b0}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_CLEAR, 32'h100, 32'h0, 1'b0, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h100, 32'h0, 1'b0, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h100, 32'h0, 1'b1, 1'b0}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h100, 32'h0, 1'b0, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h100, 32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd2, 32'd2, 1'b1}},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h100, 32'd99, 1'b0, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd2, 32'd2, 1'b1}},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h100, 32'd198, 1'b0, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd2, 32'd2, 1'b0}},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h200, 32'h0, 1'b1, 1'b1}, 1'b1,
        '{32'd0, 32'd0, 32'd3, 32'd2, 1'b0}},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h300, 32'h0, 1'b0, 1'b0}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h400, 32'h0, 1'b1, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h400, 32'd199, 1'b1, 1'b1}, 1'b0, NO_READING},
      '{'{KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b0,
        NO_READING},
      '{'{dcerm_pkg::KIND_SAMPLE, 32'h0, 32'h0, 1'b0, 1'b0}, 1'b0, NO_READING},
      '{'{dcerm_pkg::KIND_UPDATE, 32'h0, 32'd299, 1'b0, 1'b0}, 1'b1,
        '{32'd0, 32'd0, 32'd1, 32'd1, 1'b1}}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [dcerm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dcerm_pkg::CSR_DATA_W-1:0] csr_wdata;

   dcerm_req_if req_chan();
   dcerm_rsp_if rsp_chan();

   dual_channel_edge_rate_meter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the meter state, index 0 left and 1 right.
   logic [15:0] period_reg;
   logic [7:0]  min_edges_reg;
   logic        level_seen [2];
   logic [31:0] last_toggle_us [2];
   logic [31:0] window_count [2];
   logic [31:0] window_span [2];
   logic [31:0] edge_total [2];
   logic [31:0] held_speed [2];
   logic [31:0] last_update_ms;

   reading_type expected_readings [$];
   int mismatch_count;
   int quiet_cycles;
   int send_idle_pct;
   int recv_stall_pct;

   logic [1:0]  wheel_lv;
   logic [31:0] wheel_us;
   logic [31:0] wheel_ms;

   function automatic logic [31:0] average_speed(logic [31:0] count, logic [31:0] span);
      logic [63:0] scaled;
      logic [63:0] quotient;
      if (count < {24'd0, min_edges_reg} || span == 32'd0) begin
         return 32'd0;
      end
      scaled = ({32'd0, count} * {45'd0, dcerm_pkg::SPEED_SCALE})
               << dcerm_pkg::SPEED_FRAC_BITS_DEF;
      quotient = scaled / {32'd0, span};
      return (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
   endfunction

   function automatic reading_type predict_meter(meter_item_type it);
      reading_type r;
      logic [1:0] lv;
      int ch;
      lv = {it.right_level, it.left_level};
      r = '0;
      case (it.kind)
         dcerm_pkg::KIND_SAMPLE: begin
            for (ch = 0; ch < 2; ch++) begin
               if (lv[ch] != level_seen[ch]) begin
                  window_span[ch] = window_span[ch] + (it.time_us - last_toggle_us[ch]);
                  window_count[ch] = window_count[ch] + 32'd1;
                  edge_total[ch] = edge_total[ch] + 32'd1;
                  level_seen[ch] = lv[ch];
                  last_toggle_us[ch] = it.time_us;
               end
            end
         end
         dcerm_pkg::KIND_UPDATE: begin
            if (it.time_ms - last_update_ms >= {16'd0, period_reg}) begin
               for (ch = 0; ch < 2; ch++) begin
                  held_speed[ch] = average_speed(window_count[ch], window_span[ch]);
                  window_count[ch] = 32'd0;
                  window_span[ch] = 32'd0;
                  last_toggle_us[ch] = it.time_us;
               end
               last_update_ms = it.time_ms;
               r.recomputed = 1'b1;
            end
         end
         dcerm_pkg::KIND_CLEAR: begin
            for (ch = 0; ch < 2; ch++) begin
               window_count[ch] = 32'd0;
               window_span[ch] = 32'd0;
               edge_total[ch] = 32'd0;
               level_seen[ch] = lv[ch];
               last_toggle_us[ch] = it.time_us;
            end
         end
         default: ;
      endcase
      r.left_speed = held_speed[0];
      r.right_speed = held_speed[1];
      r.left_total = edge_total[0];
      r.right_total = edge_total[1];
      return r;
   endfunction

   function automatic meter_item_type make_item(logic [dcerm_pkg::KIND_W-1:0] kind,
                                                logic [31:0] us, logic [31:0] ms,
                                                logic [1:0] lv);
      meter_item_type it;
      it.kind = kind;
      it.time_us = us;
      it.time_ms = ms;
      it.left_level = lv[0];
      it.right_level = lv[1];
      return it;
   endfunction

   task automatic note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, what);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input meter_item_type it, input logic typed,
                            input reading_type reading);
      reading_type predicted;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= it.kind;
      req_chan.time_us <= it.time_us;
      req_chan.time_ms <= it.time_ms;
      req_chan.left_level <= it.left_level;
      req_chan.right_level <= it.right_level;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      predicted = predict_meter(it);
      expected_readings.push_back(typed ? reading : predicted);
      @(negedge clock);
   endtask

   task automatic drain_readings();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (expected_readings.size() != 0);
   endtask

   task automatic program_meter(input logic [15:0] period, input logic [7:0] min_edges);
      drain_readings();
      csr_we <= 1'b1;
      csr_index <= dcerm_pkg::REG_SAMPLE_PERIOD;
      csr_wdata <= period;
      @(negedge clock);
      csr_index <= dcerm_pkg::REG_MIN_EDGES;
      csr_wdata <= {8'($urandom), min_edges};
      @(negedge clock);
      csr_we <= 1'b0;
      period_reg = period;
      min_edges_reg = min_edges;
   endtask

   task automatic run_phase(input int budget);
      int done;
      int pick;
      int n;
      done = 0;
      while (done < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
               if ($urandom_range(0, 3) != 0) begin
                  wheel_us = wheel_us + $urandom_range(1, 3000);
               end
               if ($urandom_range(0, 9) < 6) wheel_lv[0] = ~wheel_lv[0];
               if ($urandom_range(0, 9) < 6) wheel_lv[1] = ~wheel_lv[1];
               send_item(make_item(dcerm_pkg::KIND_SAMPLE, wheel_us, $urandom, wheel_lv),
                         1'b0, '0);
               done++;
            end
         end else if (pick < 72) begin
            if ($urandom_range(0, 9) < 2) begin
               wheel_ms = wheel_ms + $urandom_range(0, period_reg);
            end else begin
               wheel_ms = wheel_ms + {16'd0, period_reg} + $urandom_range(0, 20);
            end
            wheel_us = wheel_us + $urandom_range(0, 500);
            send_item(make_item(dcerm_pkg::KIND_UPDATE, wheel_us, wheel_ms, 2'($urandom)),
                      1'b0, '0);
            done++;
         end else if (pick < 74) begin
            // A window of many edges within one microsecond drives the speed
            // into saturation.
            wheel_ms = last_update_ms + {16'd0, period_reg} + 32'd1;
            send_item(make_item(dcerm_pkg::KIND_UPDATE, wheel_us, wheel_ms, wheel_lv),
                      1'b0, '0);
            n = $urandom_range(34, 44);
            repeat (n) begin
               wheel_lv = ~wheel_lv;
               send_item(make_item(dcerm_pkg::KIND_SAMPLE, wheel_us, $urandom, wheel_lv),
                         1'b0, '0);
            end
            wheel_us = wheel_us + 32'd1;
            wheel_lv = ~wheel_lv;
            send_item(make_item(dcerm_pkg::KIND_SAMPLE, wheel_us, $urandom, wheel_lv),
                      1'b0, '0);
            wheel_ms = last_update_ms + {16'd0, period_reg} + 32'd1;
            send_item(make_item(dcerm_pkg::KIND_UPDATE, wheel_us, wheel_ms, wheel_lv),
                      1'b0, '0);
            done += n + 3;
         end else if (pick < 80) begin
            wheel_lv = 2'($urandom);
            wheel_us = wheel_us + $urandom_range(0, 1000);
            send_item(make_item(dcerm_pkg::KIND_CLEAR, wheel_us, $urandom, wheel_lv),
                      1'b0, '0);
            done++;
         end else if (pick < 86) begin
            send_item(make_item(KIND_UNUSED, $urandom, $urandom, 2'($urandom)), 1'b0, '0);
         end else begin
            wheel_us = $urandom;
            wheel_ms = $urandom;
            wheel_lv = 2'($urandom);
            send_item(make_item($urandom_range(0, 1) ? dcerm_pkg::KIND_UPDATE
                                                     : dcerm_pkg::KIND_SAMPLE,
                                wheel_us, wheel_ms, wheel_lv), 1'b0, '0);
            done++;
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("dual_channel_edge_rate_meter_unit: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      reading_type got;
      reading_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = '{rsp_chan.left_speed, rsp_chan.right_speed, rsp_chan.left_total,
                 rsp_chan.right_total, rsp_chan.recomputed};
         if (expected_readings.size() == 0) begin
            note_failure($sformatf("unexpected result item %h", got));
         end else begin
            want = expected_readings.pop_front();
            if (got.left_speed !== want.left_speed || got.right_speed !== want.right_speed ||
                got.left_total !== want.left_total || got.right_total !== want.right_total ||
                got.recomputed !== want.recomputed) begin
               note_failure($sformatf(
                  "expected speeds %0d %0d totals %0d %0d flag %b, got %0d %0d %0d %0d %b",
                  want.left_speed, want.right_speed, want.left_total, want.right_total,
                  want.recomputed, got.left_speed, got.right_speed, got.left_total,
                  got.right_total, got.recomputed));
            end
         end
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      int i;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.kind = dcerm_pkg::KIND_SAMPLE;
      req_chan.time_us = '0;
      req_chan.time_ms = '0;
      req_chan.left_level = 1'b1;
      req_chan.right_level = 1'b1;
      mismatch_count = 0;
      quiet_cycles = 0;
      send_idle_pct = 15;
      recv_stall_pct = 15;
      period_reg = dcerm_pkg::PERIOD_RESET;
      min_edges_reg = dcerm_pkg::MIN_EDGES_RESET;
      for (i = 0; i < 2; i++) begin
         level_seen[i] = 1'b1;
         last_toggle_us[i] = '0;
         window_count[i] = '0;
         window_span[i] = '0;
         edge_total[i] = '0;
         held_speed[i] = '0;
      end
      last_update_ms = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < 23; i++) begin
         send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].reading);
      end

      wheel_lv = 2'b00;
      wheel_us = 32'h0000_1000;
      wheel_ms = 32'd1000;

      send_idle_pct = 20;
      recv_stall_pct = 20;
      program_meter(16'd1, 8'd1);
      run_phase(225);

      send_idle_pct = 5;
      recv_stall_pct = 35;
      program_meter(16'd65535, 8'd255);
      run_phase(225);

      send_idle_pct = 0;
      recv_stall_pct = 25;
      program_meter(16'd0, 8'd0);
      run_phase(110);
      drain_readings();
      run_phase(115);

      send_idle_pct = 40;
      recv_stall_pct = 10;
      program_meter(16'($urandom_range(1, 65535)), 8'($urandom_range(1, 255)));
      run_phase(225);

      send_idle_pct = 0;
      recv_stall_pct = 0;
      program_meter(dcerm_pkg::PERIOD_RESET, dcerm_pkg::MIN_EDGES_RESET);
      run_phase(225);

      drain_readings();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_readings.size() != 0) begin
         note_failure("result items still outstanding at the end");
      end
      if (mismatch_count == 0) begin
         $display("dual_channel_edge_rate_meter_unit: match");
      end else begin
         $display("dual_channel_edge_rate_meter_unit: mismatch");
      end
      $finish;
   end

endmodule
